FILE: rtl/core/lpf_pkg.sv
// Shared types and constants for the longest palindrome finder.
`timescale 1ns / 1ps

package lpf_pkg;

	localparam int MAX_LEN_DEF = 1024;

	localparam int CH_W     = 8;
	localparam int START_W  = 10;
	localparam int LENGTH_W = 11;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            ch_valid;
		logic            last;
	} chr_t;

	typedef struct packed {
		logic [START_W-1:0]  start_res;
		logic [LENGTH_W-1:0] length;
		logic                overflow;
	} res_t;

	// Search outcome handed from the sequencer to the top level.
	typedef struct packed {
		logic                valid;
		logic [START_W-1:0]  start_res;
		logic [LENGTH_W-1:0] length;
	} srch_done_t;

	// One-hot sequencer states.
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ITER = 7'b0000010,
		S_MIR  = 7'b0000100,
		S_EXP  = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_DONE = 7'b1000000
	} seq_state_t;

endpackage

FILE: rtl/core/lpf_char_mem.sv
// Character store: one write port, two registered read ports.
`timescale 1ns / 1ps

module lpf_char_mem
	import lpf_pkg::*;
#(
	parameter int DEPTH = MAX_LEN_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [CH_W-1:0] wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr_a,
	input  logic [AW-1:0]   rd_addr_b,
	output logic [CH_W-1:0] rd_data_a,
	output logic [CH_W-1:0] rd_data_b
);

	logic [CH_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: rtl/core/lpf_rad_mem.sv
// Radius store: one write port, one registered read port.
`timescale 1ns / 1ps

module lpf_rad_mem
	import lpf_pkg::*;
#(
	parameter int DEPTH = 2 * MAX_LEN_DEF + 2,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/lpf_seq.sv
// Search sequencer: walks the interleaved string and expands each centre.
`timescale 1ns / 1ps

module lpf_seq
	import lpf_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int CW      = $clog2(MAX_LEN + 1),
	parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	parameter int PW      = $clog2(2 * MAX_LEN + 3),
	parameter int RW      = $clog2(MAX_LEN + 2)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [CW-1:0]   n,
	input  logic            done_ack,
	output logic            busy,
	output srch_done_t      done,
	// character store reads
	output logic            ch_rd_en,
	output logic [AW-1:0]   ch_rd_addr_a,
	output logic [AW-1:0]   ch_rd_addr_b,
	input  logic [CH_W-1:0] ch_rd_data_a,
	input  logic [CH_W-1:0] ch_rd_data_b,
	// radius store
	output logic            rad_wr_en,
	output logic [PW-1:0]   rad_wr_addr,
	output logic [RW-1:0]   rad_wr_data,
	output logic            rad_rd_en,
	output logic [PW-1:0]   rad_rd_addr,
	input  logic [RW-1:0]   rad_rd_data
);

	seq_state_t    state_q;
	logic [PW-1:0] top_q, i_q, re_q, rc_q, bc_q;
	logic [RW-1:0] r_q, br_q;

	logic [PW-1:0] mirror, span, k1, k2, i_plus_r, best_diff;
	logic [RW-1:0] mir_r;

	assign mirror   = PW'({rc_q, 1'b0} - {1'b0, i_q});
	assign span     = re_q - i_q;
	assign k1       = i_q + PW'(r_q);
	assign k2       = i_q - PW'(r_q);
	assign i_plus_r = k1;
	assign mir_r    = (PW'(rad_rd_data) < span) ? rad_rd_data : RW'(span);

	assign busy = (state_q != S_IDLE);

	// Character reads go out when both mirrored symbols are string bytes.
	assign ch_rd_en     = (state_q == S_EXP) && (PW'(r_q) <= i_q) &&
	                      (k1 < top_q) && !k1[0] && (k2 != '0);
	assign ch_rd_addr_a = AW'((k1 >> 1) - PW'(1));
	assign ch_rd_addr_b = AW'((k2 >> 1) - PW'(1));

	assign rad_rd_en   = (state_q == S_ITER) && (i_q < re_q);
	assign rad_rd_addr = mirror;

	assign rad_wr_en   = (state_q == S_FIN);
	assign rad_wr_addr = i_q;
	assign rad_wr_data = r_q;

	assign best_diff       = bc_q - PW'(br_q);
	assign done.valid      = (state_q == S_DONE);
	assign done.length     = (br_q != '0) ? LENGTH_W'(br_q - RW'(1)) : '0;
	assign done.start_res  = (bc_q >= PW'(br_q)) ? START_W'(best_diff >> 1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			re_q    <= '0;
			rc_q    <= '0;
			bc_q    <= '0;
			br_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						top_q   <= PW'({n, 1'b0}) + PW'(2);
						i_q     <= PW'(1);
						re_q    <= '0;
						rc_q    <= '0;
						bc_q    <= '0;
						br_q    <= '0;
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (i_q < re_q) begin
						state_q <= S_MIR;
					end else begin
						r_q     <= RW'(1);
						state_q <= S_EXP;
					end
				end
				S_MIR: begin
					r_q     <= mir_r;
					state_q <= S_EXP;
				end
				S_EXP: begin
					// odd positions are separators on both sides; sentinels never match
					if (PW'(r_q) > i_q || k1 >= top_q) begin
						state_q <= S_FIN;
					end else if (k1[0]) begin
						r_q <= r_q + RW'(1);
					end else if (k2 == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (ch_rd_data_a == ch_rd_data_b) begin
						r_q     <= r_q + RW'(1);
						state_q <= S_EXP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (i_plus_r > re_q) begin
						rc_q <= i_q;
						re_q <= i_plus_r;
					end
					if (r_q > br_q) begin
						br_q <= r_q;
						bc_q <= i_q;
					end
					if (i_q + PW'(1) == top_q) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + PW'(1);
						state_q <= S_ITER;
					end
				end
				S_DONE: begin
					if (done_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/longest_palindrome_finder.sv
// Longest palindrome finder top level: string loading, search and result register.
// Loading: a non-last item is taken every cycle while no search is pending or running.
// After the last item the search runs over 2n+1 centres; each centre passes ITER, then MIR
// if it lies inside the reach, then EXP per step, CMP per character compare, and FIN.
// The result is registered once the search is done and the result register is free; input stalls until then.
// Reset clears the count, overflow flag, sequencer and result valid; stores need no clearing.
`timescale 1ns / 1ps

module longest_palindrome_finder
	import lpf_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int RDEP  = 2 * MAX_LEN + 2;
	localparam int PW    = $clog2(2 * MAX_LEN + 3);
	localparam int RW    = $clog2(MAX_LEN + 2);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          start_q;
	logic          res_valid_q;
	res_t          res_q;

	logic          busy, chr_xfer, store_ok, done_ack;
	srch_done_t    done;

	logic            ch_rd_en;
	logic [AW-1:0]   ch_rd_addr_a, ch_rd_addr_b;
	logic [CH_W-1:0] ch_rd_data_a, ch_rd_data_b;
	logic            rad_wr_en, rad_rd_en;
	logic [PW-1:0]   rad_wr_addr, rad_rd_addr;
	logic [RW-1:0]   rad_wr_data, rad_rd_data;

	assign chr_stall = busy || start_q;
	assign chr_xfer  = chr_valid && !chr_stall;
	assign store_ok  = chr_xfer && chr.ch_valid && (count_q < CW'(MAX_LEN));
	assign done_ack  = done.valid && (!res_valid_q || !res_stall);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			start_q <= chr_xfer && chr.last;
			if (done_ack) begin
				// string is finished: next transfer begins a new one
				count_q     <= '0;
				ovf_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				if (res_valid_q && !res_stall) begin
					res_valid_q <= 1'b0;
				end
				if (store_ok) begin
					count_q <= count_q + CW'(1);
				end else if (chr_xfer && chr.ch_valid) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_ack) begin
			res_q.start_res <= done.start_res;
			res_q.length    <= done.length;
			res_q.overflow  <= ovf_q;
		end
	end

	lpf_char_mem #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_char_mem (
		.clk       (clk),
		.wr_en     (store_ok),
		.wr_addr   (count_q[AW-1:0]),
		.wr_data   (chr.ch),
		.rd_en     (ch_rd_en),
		.rd_addr_a (ch_rd_addr_a),
		.rd_addr_b (ch_rd_addr_b),
		.rd_data_a (ch_rd_data_a),
		.rd_data_b (ch_rd_data_b)
	);

	lpf_rad_mem #(
		.DEPTH (RDEP),
		.AW    (PW),
		.DW    (RW)
	) u_rad_mem (
		.clk     (clk),
		.wr_en   (rad_wr_en),
		.wr_addr (rad_wr_addr),
		.wr_data (rad_wr_data),
		.rd_en   (rad_rd_en),
		.rd_addr (rad_rd_addr),
		.rd_data (rad_rd_data)
	);

	lpf_seq #(
		.MAX_LEN (MAX_LEN),
		.CW      (CW),
		.AW      (AW),
		.PW      (PW),
		.RW      (RW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start_q),
		.n            (count_q),
		.done_ack     (done_ack),
		.busy         (busy),
		.done         (done),
		.ch_rd_en     (ch_rd_en),
		.ch_rd_addr_a (ch_rd_addr_a),
		.ch_rd_addr_b (ch_rd_addr_b),
		.ch_rd_data_a (ch_rd_data_a),
		.ch_rd_data_b (ch_rd_data_b),
		.rad_wr_en    (rad_wr_en),
		.rad_wr_addr  (rad_wr_addr),
		.rad_wr_data  (rad_wr_data),
		.rad_rd_en    (rad_rd_en),
		.rad_rd_addr  (rad_rd_addr),
		.rad_rd_data  (rad_rd_data)
	);

endmodule

FILE: sim/longest_palindrome_finder_tb.sv
// Self-checking testbench for the longest palindrome finder.
`timescale 1ns / 1ps

module longest_palindrome_finder_tb;
	import lpf_pkg::*;

	localparam int TEXT_DEPTH  = MAX_LEN_DEF;
	localparam int ARM_DEPTH   = 2 * MAX_LEN_DEF + 2;
	localparam int SYM_SEP     = 256;
	localparam int SYM_HEAD    = 257;
	localparam int SYM_TAIL    = 258;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic chr_valid = 1'b0;
	logic chr_stall;
	chr_t chr = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	chr_t pending_items[$];
	res_t expected_spans[$];

	logic [7:0]  text_mem [TEXT_DEPTH];
	int unsigned arm_len [ARM_DEPTH];
	int unsigned text_len = 0;
	bit          text_dropped = 1'b0;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	res_t        want;

	longest_palindrome_finder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #2 clk = ~clk;

	// Symbol k of the framed string: head sentinel, separators between characters, tail sentinel.
	function automatic int framed_symbol(int unsigned k);
		if (k == 0)
			return SYM_HEAD;
		if (k >= 2 * text_len + 2)
			return SYM_TAIL;
		if (k[0])
			return SYM_SEP;
		return int'(text_mem[(k - 2) / 2]);
	endfunction

	// Store one accepted character; on the last transfer run the search and queue its span.
	function automatic void absorb_transfer(chr_t item);
		int unsigned reach;
		int unsigned hub;
		int unsigned best_hub;
		int unsigned best_arm;
		int unsigned r;
		int unsigned span;
		res_t span_out;
		if (item.ch_valid) begin
			if (text_len < TEXT_DEPTH) begin
				text_mem[text_len] = item.ch;
				text_len++;
			end else begin
				text_dropped = 1'b1;
			end
		end
		if (!item.last)
			return;
		reach = 0;
		hub = 0;
		best_hub = 0;
		best_arm = 0;
		for (int unsigned i = 1; i < 2 * text_len + 2; i++) begin
			r = 1;
			if (i < reach) begin
				span = reach - i;
				r = (arm_len[2 * hub - i] < span) ? arm_len[2 * hub - i] : span;
			end
			while (r <= i && framed_symbol(i + r) == framed_symbol(i - r))
				r++;
			arm_len[i] = r;
			if (i + r > reach) begin
				hub = i;
				reach = i + r;
			end
			// strict compare keeps the earliest centre on a tie
			if (r > best_arm) begin
				best_arm = r;
				best_hub = i;
			end
		end
		span_out.length = LENGTH_W'((best_arm > 0) ? best_arm - 1 : 0);
		span_out.start_res = START_W'((best_hub >= best_arm) ? (best_hub - best_arm) / 2 : 0);
		span_out.overflow = text_dropped;
		expected_spans.push_back(span_out);
		text_len = 0;
		text_dropped = 1'b0;
	endfunction

	task automatic queue_item(input logic [7:0] c, input bit has_char, input bit is_last);
		chr_t item;
		item.ch = c;
		item.ch_valid = has_char;
		item.last = is_last;
		pending_items.push_back(item);
	endtask

	// Queue a whole string with optional ignored items mixed in and an optional empty last item.
	task automatic queue_string(input logic [7:0] s[$], input bit tail_empty,
		input int unsigned noise_pct);
		bit close_empty;
		close_empty = tail_empty || (s.size() == 0);
		for (int j = 0; j < s.size(); j++) begin
			if ($urandom_range(99) < noise_pct)
				queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
			queue_item(s[j], 1'b1, !close_empty && (j == s.size() - 1));
		end
		if (close_empty)
			queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic queue_random_strings(input int unsigned item_goal);
		int unsigned queued;
		int unsigned len;
		int unsigned half;
		int unsigned style;
		bit tail_empty;
		logic [7:0] alpha [3];
		logic [7:0] s[$];
		queued = 0;
		while (queued < item_goal) begin
			s.delete();
			len = ($urandom_range(99) < 8) ? $urandom_range(40, 120) : $urandom_range(0, 12);
			style = $urandom_range(3);
			foreach (alpha[a])
				alpha[a] = 8'($urandom_range(255));
			case (style)
				0: begin
					for (int j = 0; j < len; j++)
						s.push_back(8'($urandom_range(255)));
				end
				1: begin
					for (int j = 0; j < len; j++)
						s.push_back(alpha[$urandom_range(1)]);
				end
				2: begin
					half = len / 2;
					for (int j = 0; j < half; j++)
						s.push_back(alpha[$urandom_range(2)]);
					if (len % 2)
						s.push_back(8'($urandom_range(255)));
					for (int j = half - 1; j >= 0; j--)
						s.push_back(s[j]);
					repeat ($urandom_range(2))
						s.push_front(8'($urandom_range(255)));
					repeat ($urandom_range(2))
						s.push_back(8'($urandom_range(255)));
				end
				default: begin
					for (int j = 0; j < len; j++)
						s.push_back(alpha[0]);
					if (len > 0)
						s[$urandom_range(len - 1)] = alpha[1];
				end
			endcase
			tail_empty = ($urandom_range(99) < 20);
			queue_string(s, tail_empty, 4);
			queued += s.size() + ((tail_empty || s.size() == 0) ? 1 : 0);
		end
	endtask

	// Hold until every queued item has transferred and every span has come back.
	task automatic wait_drained();
		while (pending_items.size() != 0 || chr_valid || expected_spans.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			chr_valid <= 1'b0;
			chr <= '0;
		end else if (!chr_valid || !chr_stall) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				chr_valid <= 1'b1;
				chr <= pending_items.pop_front();
			end else begin
				chr_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_spans.size() == 0) begin
					$display("%0t: unexpected result start_res=%0d length=%0d overflow=%0b",
						$time, res.start_res, res.length, res.overflow);
					error_count++;
				end else begin
					want = expected_spans.pop_front();
					if (res.start_res !== want.start_res) begin
						$display("%0t: start_res mismatch expected %0d actual %0d",
							$time, want.start_res, res.start_res);
						error_count++;
					end
					if (res.length !== want.length) begin
						$display("%0t: length mismatch expected %0d actual %0d",
							$time, want.length, res.length);
						error_count++;
					end
					if (res.overflow !== want.overflow) begin
						$display("%0t: overflow mismatch expected %0b actual %0b",
							$time, want.overflow, res.overflow);
						error_count++;
					end
				end
			end
			if (chr_valid && !chr_stall)
				absorb_transfer(chr);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_spans.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] s[$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty string, single top byte, ties, separator-like bytes, even palindrome, no repeat
		queue_item(8'h5A, 1'b0, 1'b1);
		s = '{8'hFF};
		queue_string(s, 1'b0, 0);
		s = '{8'h61, 8'h62, 8'h61, 8'h62};
		queue_string(s, 1'b0, 0);
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'hC3, 1'b0, 1'b0);
		queue_item(8'h23, 1'b1, 1'b0);
		queue_item(8'h24, 1'b1, 1'b0);
		queue_item(8'h23, 1'b1, 1'b0);
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'hFF, 1'b0, 1'b1);
		s = '{8'hFF, 8'h00, 8'h00, 8'hFF};
		queue_string(s, 1'b0, 0);
		s = '{8'h78, 8'h79, 8'h7A};
		queue_string(s, 1'b0, 0);
		wait_drained();

		// overrun the store: the tail is dropped and the full store is one palindrome
		s.delete();
		repeat (TEXT_DEPTH + 6)
			s.push_back(8'h61);
		queue_string(s, 1'b0, 0);
		wait_drained();

		queue_random_strings(150);
		wait_drained();

		send_idle_pct = 76;
		queue_random_strings(150);
		wait_drained();

		send_idle_pct = 0;
		stall_pct = 76;
		queue_random_strings(150);
		wait_drained();

		send_idle_pct = 28;
		stall_pct = 28;
		queue_random_strings(150);
		wait_drained();

		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
